>>> rtl/elp_pkg.sv
package elp_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;

   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_CMATCH    = 4'd1,
      PH_LEADWS    = 4'd2,
      PH_NAME      = 4'd3,
      PH_AFTERNAME = 4'd4,
      PH_VALUE     = 4'd5,
      PH_ESC       = 4'd6,
      PH_OCT       = 4'd7,
      PH_HEX       = 4'd8,
      PH_T_SKIP    = 4'd9,
      PH_T_CLEAR   = 4'd10,
      PH_T_INVALID = 4'd11,
      PH_T_SYNTAX  = 4'd12,
      PH_T_UNSET   = 4'd13,
      PH_T_SET     = 4'd14
   } phase_type;

   typedef enum logic [2:0] {
      TOK_NAME    = 3'd0,
      TOK_VALUE   = 3'd1,
      TOK_SET     = 3'd2,
      TOK_UNSET   = 3'd3,
      TOK_INVALID = 3'd4,
      TOK_SYNTAX  = 3'd5,
      TOK_CLEAR   = 3'd6,
      TOK_SKIP    = 3'd7
   } token_type;

   // one or two results caused by one input transfer
   typedef struct packed {
      logic        two;
      token_type   tok0;
      logic [7:0]  byte0;
      token_type   tok1;
      logic [7:0]  byte1;
      logic [15:0] line_num;
      logic [15:0] err_num;
   } bundle_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha_us(input logic [7:0] c);
      return (c == 8'h5F) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h37);
   endfunction

   // bit 4 flags a valid hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      return r;
   endfunction

   function automatic logic [7:0] meta_char(input logic [2:0] idx);
      logic [7:0] r;
      unique case (idx)
         3'd0: r = CH_HASH;
         3'd1: r = 8'h3A;
         3'd2: r = 8'h63;
         3'd3: r = 8'h6C;
         3'd4: r = 8'h65;
         3'd5: r = 8'h61;
         3'd6: r = 8'h72;
         3'd7: r = 8'h3A;
         default: r = 8'h3A;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] named_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h61:   r = 8'h07;
         8'h62:   r = 8'h08;
         8'h74:   r = 8'h09;
         8'h6E:   r = 8'h0A;
         8'h76:   r = 8'h0B;
         8'h66:   r = 8'h0C;
         8'h72:   r = 8'h0D;
         8'h65:   r = 8'h1B;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/elp_front.sv
module elp_front
   import elp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       in_end,
   input  logic [7:0] in_ch,
   output logic       push,
   input  logic       push_ready,
   output bundle_type push_data
);

   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   phase_type             phase_ff, phase_in;
   logic [3:0]            meta_ff, meta_in;
   logic [7:0]            acc_ff, acc_in;
   logic [1:0]            dcnt_ff, dcnt_in;
   logic [COUNT_BITS-1:0] line_ff, line_in;
   logic [COUNT_BITS-1:0] err_ff, err_in;

   logic       accept;
   logic       n0, n1, vb_go;
   token_type  t0, t1;
   logic [7:0] b0, b1;
   logic [4:0] hx;
   logic [7:0] oct_acc, hex_acc;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         meta_ff  <= '0;
         acc_ff   <= '0;
         dcnt_ff  <= '0;
         line_ff  <= '0;
         err_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         meta_ff  <= meta_in;
         acc_ff   <= acc_in;
         dcnt_ff  <= dcnt_in;
         line_ff  <= line_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      meta_in  = meta_ff;
      acc_in   = acc_ff;
      dcnt_in  = dcnt_ff;
      line_in  = line_ff;
      err_in   = err_ff;
      n0       = 1'b0;
      n1       = 1'b0;
      vb_go    = 1'b0;
      t0       = TOK_SKIP;
      t1       = TOK_SKIP;
      b0       = 8'd0;
      b1       = 8'd0;
      hx       = hex_val(in_ch);
      oct_acc  = {acc_ff[4:0], in_ch[2:0]};
      hex_acc  = {acc_ff[3:0], hx[3:0]};
      if (accept) begin
         if (phase_ff == PH_START && line_ff != CountMax) line_in = line_ff + 1'b1;
         if (in_end) begin
            n0       = 1'b1;
            phase_in = PH_START;
            meta_in  = '0;
            acc_in   = '0;
            dcnt_in  = '0;
            unique case (phase_ff)
               PH_CMATCH:   t0 = (meta_ff >= 4'd8) ? TOK_CLEAR : TOK_SKIP;
               PH_NAME, PH_AFTERNAME, PH_T_UNSET: t0 = TOK_UNSET;
               PH_OCT: begin
                  if (acc_ff != 8'd0) begin
                     n1 = 1'b1;
                     t0 = TOK_VALUE;
                     b0 = acc_ff;
                     t1 = TOK_SET;
                  end else begin
                     t0 = TOK_SET;
                  end
               end
               PH_VALUE, PH_ESC, PH_HEX, PH_T_SET: t0 = TOK_SET;
               PH_T_CLEAR:  t0 = TOK_CLEAR;
               PH_T_INVALID: begin
                  t0 = TOK_INVALID;
                  if (err_ff != CountMax) err_in = err_ff + 1'b1;
               end
               PH_T_SYNTAX: t0 = TOK_SYNTAX;
               PH_START, PH_LEADWS, PH_T_SKIP: t0 = TOK_SKIP;
               default:     t0 = TOK_SKIP;
            endcase
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (in_ch == CH_HASH) begin
                     phase_in = PH_CMATCH;
                     meta_in  = 4'd1;
                  end else if (is_ws(in_ch)) begin
                     phase_in = PH_LEADWS;
                  end else if (in_ch == CH_NUL) begin
                     phase_in = PH_T_SKIP;
                  end else if (is_alpha_us(in_ch)) begin
                     n0 = 1'b1;
                     t0 = TOK_NAME;
                     b0 = in_ch;
                     phase_in = PH_NAME;
                  end else begin
                     phase_in = PH_T_INVALID;
                  end
               end
               PH_CMATCH: begin
                  if (meta_ff >= 4'd8) begin
                     phase_in = (in_ch == CH_NUL || is_ws(in_ch)) ? PH_T_CLEAR : PH_T_SKIP;
                  end else if (in_ch == CH_NUL) begin
                     phase_in = PH_T_SKIP;
                  end else if (in_ch == meta_char(meta_ff[2:0])) begin
                     meta_in = 4'(meta_ff + 4'd1);
                  end else begin
                     phase_in = PH_T_SKIP;
                  end
               end
               PH_LEADWS: begin
                  if (is_ws(in_ch)) begin
                     phase_in = PH_LEADWS;
                  end else if (in_ch == CH_NUL) begin
                     phase_in = PH_T_SKIP;
                  end else if (is_alpha_us(in_ch)) begin
                     n0 = 1'b1;
                     t0 = TOK_NAME;
                     b0 = in_ch;
                     phase_in = PH_NAME;
                  end else begin
                     phase_in = PH_T_INVALID;
                  end
               end
               PH_NAME, PH_AFTERNAME: begin
                  if (phase_ff == PH_NAME && (is_alpha_us(in_ch) || is_digit(in_ch))) begin
                     n0 = 1'b1;
                     t0 = TOK_NAME;
                     b0 = in_ch;
                  end else if (is_ws(in_ch)) begin
                     phase_in = PH_AFTERNAME;
                  end else if (in_ch == CH_EQUALS) begin
                     phase_in = PH_VALUE;
                  end else if (in_ch == CH_NUL) begin
                     phase_in = PH_T_UNSET;
                  end else begin
                     phase_in = PH_T_SYNTAX;
                  end
               end
               PH_VALUE: vb_go = 1'b1;
               PH_ESC: begin
                  if (is_octal(in_ch)) begin
                     acc_in   = {5'd0, in_ch[2:0]};
                     dcnt_in  = 2'd1;
                     phase_in = PH_OCT;
                  end else if (in_ch == CH_X) begin
                     acc_in   = '0;
                     dcnt_in  = '0;
                     phase_in = PH_HEX;
                  end else if (in_ch == CH_NUL) begin
                     phase_in = PH_T_SET;
                  end else begin
                     n0 = 1'b1;
                     t0 = TOK_VALUE;
                     b0 = named_escape(in_ch);
                     phase_in = PH_VALUE;
                  end
               end
               PH_OCT: begin
                  if (is_octal(in_ch)) begin
                     if (dcnt_ff >= 2'd2) begin
                        if (oct_acc != 8'd0) begin
                           n0 = 1'b1;
                           t0 = TOK_VALUE;
                           b0 = oct_acc;
                        end
                        acc_in   = '0;
                        dcnt_in  = '0;
                        phase_in = PH_VALUE;
                     end else begin
                        acc_in  = oct_acc;
                        dcnt_in = 2'(dcnt_ff + 2'd1);
                     end
                  end else begin
                     if (acc_ff != 8'd0) begin
                        n0 = 1'b1;
                        t0 = TOK_VALUE;
                        b0 = acc_ff;
                     end
                     acc_in   = '0;
                     dcnt_in  = '0;
                     phase_in = PH_VALUE;
                     vb_go    = 1'b1;
                  end
               end
               PH_HEX: begin
                  if (hx[4]) begin
                     if (dcnt_ff >= 2'd1) begin
                        if (hex_acc != 8'd0) begin
                           n0 = 1'b1;
                           t0 = TOK_VALUE;
                           b0 = hex_acc;
                        end
                        acc_in   = '0;
                        dcnt_in  = '0;
                        phase_in = PH_VALUE;
                     end else begin
                        acc_in  = hex_acc;
                        dcnt_in = 2'd1;
                     end
                  end else begin
                     acc_in   = '0;
                     dcnt_in  = '0;
                     phase_in = PH_VALUE;
                     vb_go    = 1'b1;
                  end
               end
               PH_T_SKIP, PH_T_CLEAR, PH_T_INVALID, PH_T_SYNTAX, PH_T_UNSET, PH_T_SET:
                  phase_in = phase_ff;
               default: phase_in = phase_ff;
            endcase
            // plain value byte, possibly behind a flushed octal escape or a dropped hex escape
            if (vb_go) begin
               if (in_ch == CH_NUL) begin
                  phase_in = PH_T_SET;
               end else if (in_ch == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else if (n0) begin
                  n1 = 1'b1;
                  t1 = TOK_VALUE;
                  b1 = in_ch;
               end else begin
                  n0 = 1'b1;
                  t0 = TOK_VALUE;
                  b0 = in_ch;
               end
            end
         end
      end
   end

   assign push               = accept && n0;
   assign push_data.two      = n1;
   assign push_data.tok0     = t0;
   assign push_data.byte0    = b0;
   assign push_data.tok1     = t1;
   assign push_data.byte1    = b1;
   assign push_data.line_num = 16'(line_in);
   assign push_data.err_num  = 16'(err_in);

endmodule

>>> rtl/elp_queue.sv
module elp_queue
   import elp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       push_ready,
   input  bundle_type push_data,
   output logic       head_valid,
   input  logic       pop,
   output bundle_type head_data
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] Full    = CntW'(QUEUE_DEPTH);

   bundle_type        slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != Full);
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LastPtr) ? '0 : PtrW'(wr_ff + 1'b1);
      if (do_pop)  rd_in = (rd_ff == LastPtr) ? '0 : PtrW'(rd_ff + 1'b1);
      if (do_push && !do_pop) cnt_in = CntW'(cnt_ff + 1'b1);
      else if (do_pop && !do_push) cnt_in = CntW'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

>>> rtl/elp_back.sv
module elp_back
   import elp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  bundle_type  head_data,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output token_type   out_token,
   output logic [7:0]  out_byte,
   output logic        out_last,
   output logic [15:0] out_line,
   output logic [15:0] out_err
);

   logic sub_ff, sub_in;
   logic take;

   assign out_valid = head_valid;
   assign take      = head_valid && out_ready;
   assign out_token = sub_ff ? head_data.tok1 : head_data.tok0;
   assign out_byte  = sub_ff ? head_data.byte1 : head_data.byte0;
   assign out_last  = !head_data.two || sub_ff;
   assign out_line  = head_data.line_num;
   assign out_err   = head_data.err_num;

   always_comb begin
      sub_in = sub_ff;
      pop    = 1'b0;
      if (take) begin
         if (head_data.two && !sub_ff) begin
            sub_in = 1'b1;
         end else begin
            sub_in = 1'b0;
            pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sub_ff <= 1'b0;
      else       sub_ff <= sub_in;
   end

endmodule

>>> rtl/env_line_parser_with_escapes.sv
// channel   dir  tdata                                     tuser      tlast
// req_      in   [7:0] ch                                  [0] kind   -
// rsp_      out  [7:0] byte_value [23:8] line_number       [2:0] token last
//                [39:24] error_count
//
// One input transfer per cycle. The classifier updates its line state in
// the cycle of the transfer and queues up to two results; the output side
// drains one result per cycle unless rsp_tready is low; an item with two results
// leaves in order, tlast on the second. req_tready drops only when the result queue is full.
// Synchronous reset returns to the start of a line with both counters cleared.
module env_line_parser_with_escapes
   import elp_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] byte_value, [23:8] line_number, [39:24] error_count
   output logic [2:0]  rsp_tuser,   // [2:0] token
   output logic        rsp_tlast
);

   logic       push, push_ready, head_valid, pop;
   bundle_type push_data, head_data;
   token_type  out_token;
   logic [7:0]  out_byte;
   logic [15:0] out_line, out_err;

   elp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_end     (req_tuser),
      .in_ch      (req_tdata),
      .push       (push),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   elp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   elp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_token  (out_token),
      .out_byte   (out_byte),
      .out_last   (rsp_tlast),
      .out_line   (out_line),
      .out_err    (out_err)
   );

   assign rsp_tuser = out_token;
   assign rsp_tdata = {out_err, out_line, out_byte};

endmodule

>>> tb/line_token_checker.sv
`timescale 1ns / 1ps
module line_token_checker
   import elp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output logic [7:0]  tokens_seen
);

   localparam logic [63:0] CLEAR_TAG = "#:clear:";
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS_DEFAULT) - 64'd1);

   typedef struct packed {
      token_type   tok;
      logic [7:0]  val;
      logic        last;
      logic [15:0] line;
      logic [15:0] errs;
   } line_result_type;

   phase_type       phase;
   logic [3:0]      tag_hits;
   logic [7:0]      esc_acc;
   logic [1:0]      esc_digits;
   logic [31:0]     line_cnt;
   logic [31:0]     err_cnt;
   line_result_type step_out [2];
   int              step_n;
   line_result_type expected_results [$];
   int              fails;
   int              seen;
   logic [7:0]      tok_mask;

   function automatic logic blank_char(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic name_head(input logic [7:0] c);
      return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic name_tail(input logic [7:0] c);
      return name_head(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic octal_char(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic int hex_weight(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] c);
      case (c)
         "a":     return 8'h07;
         "b":     return 8'h08;
         "t":     return 8'h09;
         "n":     return 8'h0A;
         "v":     return 8'h0B;
         "f":     return 8'h0C;
         "r":     return 8'h0D;
         "e":     return 8'h1B;
         default: return c;
      endcase
   endfunction

   function automatic void add_result(input token_type t, input logic [7:0] b);
      step_out[step_n].tok = t;
      step_out[step_n].val = b;
      step_n++;
   endfunction

   function automatic void value_char(input logic [7:0] c);
      if (c == CH_NUL) begin
         phase = PH_T_SET;
      end else if (c == CH_BSLASH) begin
         phase = PH_ESC;
      end else begin
         add_result(TOK_VALUE, c);
      end
   endfunction

   function automatic void flush_octal();
      if (esc_acc != 8'h00) add_result(TOK_VALUE, esc_acc);
      esc_acc    = 8'h00;
      esc_digits = 2'd0;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      int d;
      case (phase)
         PH_START: begin
            if (c == CH_HASH) begin
               phase    = PH_CMATCH;
               tag_hits = 4'd1;
            end else if (blank_char(c)) begin
               phase = PH_LEADWS;
            end else if (c == CH_NUL) begin
               phase = PH_T_SKIP;
            end else if (name_head(c)) begin
               add_result(TOK_NAME, c);
               phase = PH_NAME;
            end else begin
               phase = PH_T_INVALID;
            end
         end
         PH_CMATCH: begin
            if (tag_hits >= 4'd8) begin
               phase = (c == CH_NUL || blank_char(c)) ? PH_T_CLEAR : PH_T_SKIP;
            end else if (c == CH_NUL) begin
               phase = PH_T_SKIP;
            end else if (c == CLEAR_TAG[63 - 8 * tag_hits[2:0] -: 8]) begin
               tag_hits++;
            end else begin
               phase = PH_T_SKIP;
            end
         end
         PH_LEADWS: begin
            if (blank_char(c)) begin
            end else if (c == CH_NUL) begin
               phase = PH_T_SKIP;
            end else if (name_head(c)) begin
               add_result(TOK_NAME, c);
               phase = PH_NAME;
            end else begin
               phase = PH_T_INVALID;
            end
         end
         PH_NAME, PH_AFTERNAME: begin
            if (phase == PH_NAME && name_tail(c)) begin
               add_result(TOK_NAME, c);
            end else if (blank_char(c)) begin
               phase = PH_AFTERNAME;
            end else if (c == CH_EQUALS) begin
               phase = PH_VALUE;
            end else if (c == CH_NUL) begin
               phase = PH_T_UNSET;
            end else begin
               phase = PH_T_SYNTAX;
            end
         end
         PH_VALUE: value_char(c);
         PH_ESC: begin
            if (octal_char(c)) begin
               esc_acc    = {5'd0, c[2:0]};
               esc_digits = 2'd1;
               phase      = PH_OCT;
            end else if (c == CH_X) begin
               esc_acc    = 8'h00;
               esc_digits = 2'd0;
               phase      = PH_HEX;
            end else if (c == CH_NUL) begin
               phase = PH_T_SET;
            end else begin
               add_result(TOK_VALUE, escape_byte(c));
               phase = PH_VALUE;
            end
         end
         PH_OCT: begin
            if (octal_char(c)) begin
               esc_acc = {esc_acc[4:0], c[2:0]};
               if (esc_digits >= 2'd2) begin
                  flush_octal();
                  phase = PH_VALUE;
               end else begin
                  esc_digits++;
               end
            end else begin
               flush_octal();
               phase = PH_VALUE;
               value_char(c);
            end
         end
         PH_HEX: begin
            d = hex_weight(c);
            if (d >= 0) begin
               esc_acc = {esc_acc[3:0], 4'(d)};
               if (esc_digits >= 2'd1) begin
                  if (esc_acc != 8'h00) add_result(TOK_VALUE, esc_acc);
                  esc_acc    = 8'h00;
                  esc_digits = 2'd0;
                  phase      = PH_VALUE;
               end else begin
                  esc_digits = 2'd1;
               end
            end else begin
               esc_acc    = 8'h00;
               esc_digits = 2'd0;
               phase      = PH_VALUE;
               value_char(c);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void close_line();
      token_type t;
      case (phase)
         PH_CMATCH: t = (tag_hits >= 4'd8) ? TOK_CLEAR : TOK_SKIP;
         PH_NAME, PH_AFTERNAME, PH_T_UNSET: t = TOK_UNSET;
         PH_OCT: begin
            flush_octal();
            t = TOK_SET;
         end
         PH_VALUE, PH_ESC, PH_HEX, PH_T_SET: t = TOK_SET;
         PH_T_CLEAR: t = TOK_CLEAR;
         PH_T_INVALID: begin
            t = TOK_INVALID;
            if (err_cnt < COUNT_MAX) err_cnt++;
         end
         PH_T_SYNTAX: t = TOK_SYNTAX;
         default: t = TOK_SKIP;
      endcase
      add_result(t, 8'h00);
      phase      = PH_START;
      tag_hits   = 4'd0;
      esc_acc    = 8'h00;
      esc_digits = 2'd0;
   endfunction

   function automatic void predict_transfer(input logic kind, input logic [7:0] c);
      step_n = 0;
      if (phase == PH_START && line_cnt < COUNT_MAX) line_cnt++;
      if (kind) close_line();
      else take_char(c);
      for (int k = 0; k < step_n; k++) begin
         step_out[k].last = (k == step_n - 1);
         step_out[k].line = line_cnt[15:0];
         step_out[k].errs = err_cnt[15:0];
         expected_results.push_back(step_out[k]);
      end
   endfunction

   function automatic void check_result();
      line_result_type want;
      seen++;
      tok_mask[rsp_tuser] = 1'b1;
      if (expected_results.size() == 0) begin
         fails++;
         if (fails <= 10)
            $display("unexpected result: tok=%0d byte=%h last=%b line=%0d err=%0d",
                     rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[23:8], rsp_tdata[39:24]);
      end else begin
         want = expected_results.pop_front();
         if (rsp_tuser !== want.tok || rsp_tdata[7:0] !== want.val || rsp_tlast !== want.last ||
             rsp_tdata[23:8] !== want.line || rsp_tdata[39:24] !== want.errs) begin
            fails++;
            if (fails <= 10) begin
               $display("mismatch: want tok=%0d byte=%h last=%b line=%0d err=%0d",
                        want.tok, want.val, want.last, want.line, want.errs);
               $display("          got  tok=%0d byte=%h last=%b line=%0d err=%0d",
                        rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[23:8], rsp_tdata[39:24]);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_START;
         tag_hits   = 4'd0;
         esc_acc    = 8'h00;
         esc_digits = 2'd0;
         line_cnt   = 32'd0;
         err_cnt    = 32'd0;
         fails      = 0;
         seen       = 0;
         tok_mask   = 8'h00;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) predict_transfer(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      fail_count   <= fails;
      pending      <= expected_results.size();
      results_seen <= seen;
      tokens_seen  <= tok_mask;
   end

endmodule

>>> tb/env_line_parser_with_escapes_test.sv
`timescale 1ns / 1ps
module env_line_parser_with_escapes_test;
   import elp_pkg::*;

   localparam int ITEM_GOAL   = 1050;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int         fail_count;
   int         pending;
   int         results_seen;
   logic [7:0] tokens_seen;

   int         send_idle  = 0;
   int         recv_idle  = 0;
   int         items_sent = 0;
   int         lines_sent = 0;
   int         cycles     = 0;
   logic [7:0] line_bytes [$];

   string clear_tag  = "#:clear:";
   string esc_names  = "abtnvfre\\";
   string hex_digits = "0123456789abcdefABCDEF";

   always #5 clock = ~clock;

   env_line_parser_with_escapes u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   line_token_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen),
      .tokens_seen  (tokens_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding", pending);
         $display("FAIL env_line_parser_with_escapes");
         $finish;
      end
   end

   task automatic send(input logic kind, input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= kind ? 8'($urandom_range(0, 255)) : ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send(1'b0, line_bytes[i]);
      send(1'b1, 8'h00);
      lines_sent++;
      line_bytes.delete();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   function automatic logic name_ok(input logic [7:0] c);
      return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] pick_head();
      int r;
      r = $urandom_range(0, 52);
      if (r == 0) return "_";
      if (r <= 26) return 8'("A" + r - 1);
      return 8'("a" + r - 27);
   endfunction

   function automatic logic [7:0] pick_tail();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return pick_head();
   endfunction

   function automatic logic [7:0] pick_blank();
      if ($urandom_range(0, 1) == 0) return " ";
      return 8'($urandom_range(9, 13));
   endfunction

   function automatic logic [7:0] pick_hex();
      if ($urandom_range(0, 3) == 0) return "0";
      return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
   endfunction

   task automatic push_junk(input int most);
      repeat ($urandom_range(0, most)) line_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic push_name();
      line_bytes.push_back(pick_head());
      repeat ($urandom_range(0, 4)) line_bytes.push_back(pick_tail());
   endtask

   task automatic push_value();
      logic [7:0] b;
      int k;
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               b = 8'($urandom_range(1, 255));
               line_bytes.push_back(b == CH_BSLASH ? 8'h7E : b);
            end
            2: begin
               line_bytes.push_back(CH_BSLASH);
               k = $urandom_range(0, 9);
               if (k < 9) line_bytes.push_back(esc_names[k]);
               else line_bytes.push_back(8'($urandom_range(1, 255)));
            end
            3: begin
               line_bytes.push_back(CH_BSLASH);
               repeat ($urandom_range(1, 3)) line_bytes.push_back(8'("0" + $urandom_range(0, 7)));
            end
            4: begin
               line_bytes.push_back(CH_BSLASH);
               line_bytes.push_back(CH_X);
               repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_hex());
            end
            5: begin
               line_bytes.push_back(CH_BSLASH);
               line_bytes.push_back(8'($urandom_range(128, 255)));
            end
            default: begin
               b = 8'($urandom_range(32, 126));
               line_bytes.push_back(b == CH_BSLASH ? 8'h2E : b);
            end
         endcase
      end
      case ($urandom_range(0, 5))
         0: line_bytes.push_back(CH_BSLASH);
         1: begin
            line_bytes.push_back(CH_NUL);
            push_junk(3);
         end
         default: ;
      endcase
   endtask

   task automatic build_line();
      logic [7:0] b;
      int n;
      case ($urandom_range(0, 19))
         0: ;
         1, 2: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) line_bytes.push_back(clear_tag[i]);
            case ($urandom_range(0, 3))
               0: line_bytes.push_back(pick_blank());
               1: line_bytes.push_back(CH_NUL);
               2: line_bytes.push_back(8'($urandom_range(0, 255)));
               default: ;
            endcase
            push_junk(3);
         end
         3, 4: begin
            if ($urandom_range(0, 2) == 0) line_bytes.push_back(pick_blank());
            push_name();
            if ($urandom_range(0, 1) == 0) line_bytes.push_back(pick_blank());
            if ($urandom_range(0, 3) == 0) begin
               line_bytes.push_back(CH_NUL);
               push_junk(3);
            end
         end
         14, 15: begin
            n = $urandom_range(0, 1);
            if (n == 1) line_bytes.push_back(pick_blank());
            do b = 8'($urandom_range(1, 255));
            while (name_ok(b) || b == " " || (b >= 8'h09 && b <= 8'h0D) ||
                   (n == 0 && b == CH_HASH));
            line_bytes.push_back(b);
            push_junk(4);
         end
         16, 17: begin
            push_name();
            if ($urandom_range(0, 1) == 0) begin
               line_bytes.push_back(pick_blank());
               line_bytes.push_back(pick_tail());
            end else begin
               do b = 8'($urandom_range(1, 255));
               while (name_ok(b) || (b >= "0" && b <= "9") || b == CH_EQUALS || b == " " ||
                      (b >= 8'h09 && b <= 8'h0D));
               line_bytes.push_back(b);
            end
            push_junk(4);
         end
         18, 19: push_junk(6);
         default: begin
            if ($urandom_range(0, 3) == 0) line_bytes.push_back(pick_blank());
            push_name();
            if ($urandom_range(0, 3) == 0) line_bytes.push_back(pick_blank());
            line_bytes.push_back(CH_EQUALS);
            push_value();
         end
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle = 30;
      recv_idle = 79;

      send_line();
      push_text("A=");
      line_bytes.push_back(8'hFF);
      push_text("\\e");
      send_line();
      push_text(" #");
      send_line();
      push_text("b?");
      send_line();
      push_text("c");
      line_bytes.push_back(CH_NUL);
      push_text("z");
      send_line();
      push_text("#:clear:");
      send_line();

      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle = 30;
               recv_idle = 79;
            end
            1: begin
               send_idle = 79;
               recv_idle = 30;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         while (items_sent < ITEM_GOAL * (stage + 1) / 3) begin
            build_line();
            send_line();
         end
         // hold off until every queued result has come out
         drain();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d transfers over %0d lines, checked %0d results", items_sent,
               lines_sent, results_seen);
      $display("token kinds observed (bit per token): %b", tokens_seen);
      if (pending != 0) $display("%0d expected results never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS env_line_parser_with_escapes");
      end else begin
         $display("FAIL env_line_parser_with_escapes");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/elp_pkg.sv
rtl/elp_front.sv
rtl/elp_queue.sv
rtl/elp_back.sv
rtl/env_line_parser_with_escapes.sv
tb/line_token_checker.sv
tb/env_line_parser_with_escapes_test.sv
